// File: sv/cmil_pkg.sv
// ----------------------------------------------------------------------------
// cmil_pkg
// Shared widths, codes and types of the interpolating colormap lookup.
// ----------------------------------------------------------------------------
package cmil_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int ADDR_W        = 8;
    localparam int FRACTION_BITS = 16;
    localparam int COLOR_BITS    = 16;
    localparam int COMP_W        = 17;
    localparam int VALUE_W       = 18;
    localparam int FRAC_W        = FRACTION_BITS + 1;
    localparam int ENTRIES_W     = 9;
    localparam int PIXEL_W       = 8;
    localparam int POS_W         = FRAC_W + ADDR_W;
    localparam int PROD_W        = FRAC_W + COMP_W;
    localparam int SAT_W         = FRACTION_BITS + COLOR_BITS + 1;
    localparam int SCALED_W      = SAT_W + PIXEL_W;

    localparam logic [FRAC_W-1:0]    ONE        = FRAC_W'(1) << FRACTION_BITS;
    localparam logic [SAT_W-1:0]     FULL_SCALE = SAT_W'(1) << (FRACTION_BITS + COLOR_BITS);
    localparam logic [SCALED_W-1:0]  ROUND_HALF =
        SCALED_W'(1) << (FRACTION_BITS + COLOR_BITS - 1);

    // item operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // register map
    localparam int                   APB_ADDR_W    = 3;
    localparam logic                 REG_ENTRIES   = 1'b0;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 9'd256;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } color_entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] last_index;   // effective entries in use minus one
    } cmil_cfg_t;

endpackage

// File: sv/cmil_if.sv
// ----------------------------------------------------------------------------
// cmil_if
// Valid/ready channels of the colormap lookup: request words and pixel words.
// ----------------------------------------------------------------------------
interface cmil_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [cmil_pkg::ADDR_W-1:0]    entry_index;
    logic [cmil_pkg::COMP_W-1:0]    red_in;
    logic [cmil_pkg::COMP_W-1:0]    green_in;
    logic [cmil_pkg::COMP_W-1:0]    blue_in;
    logic signed [cmil_pkg::VALUE_W-1:0] value;

    modport source (output valid, operation, entry_index, red_in, green_in, blue_in, value,
                    input ready);
    modport sink   (input valid, operation, entry_index, red_in, green_in, blue_in, value,
                    output ready);
endinterface

interface cmil_out_if;
    logic                           valid;
    logic                           ready;
    logic [cmil_pkg::PIXEL_W-1:0]   red;
    logic [cmil_pkg::PIXEL_W-1:0]   green;
    logic [cmil_pkg::PIXEL_W-1:0]   blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: sv/cmil_cfg_regs.sv
// ----------------------------------------------------------------------------
// cmil_cfg_regs
// APB register file: entries in use, clamped to the table's range for use.
// ----------------------------------------------------------------------------
module cmil_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cmil_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output cmil_pkg::cmil_cfg_t               cfg
);

    logic [cmil_pkg::ENTRIES_W-1:0] entries_reg;
    logic [cmil_pkg::ENTRIES_W-1:0] entries_next;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == cmil_pkg::REG_ENTRIES);

    always_comb
    begin
        entries_next = entries_reg;
        if (wr_en)
        begin
            entries_next = pwdata[cmil_pkg::ENTRIES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= cmil_pkg::ENTRIES_RESET;
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    assign prdata = (paddr[2] == cmil_pkg::REG_ENTRIES) ?
                    32'(entries_reg) : 32'd0;

    // clamp to [2, TABLE_DEPTH] and hand on the last usable index
    always_comb
    begin
        if (entries_reg < cmil_pkg::ENTRIES_W'(2))
        begin
            cfg.last_index = cmil_pkg::ADDR_W'(1);
        end
        else if (entries_reg > cmil_pkg::ENTRIES_W'(cmil_pkg::TABLE_DEPTH))
        begin
            cfg.last_index = cmil_pkg::ADDR_W'(cmil_pkg::TABLE_DEPTH - 1);
        end
        else
        begin
            cfg.last_index = cmil_pkg::ADDR_W'(entries_reg - cmil_pkg::ENTRIES_W'(1));
        end
    end

endmodule

// File: sv/cmil_table_ram.sv
// ----------------------------------------------------------------------------
// cmil_table_ram
// Color table: one write port, two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
module cmil_table_ram
(
    input  logic                            clk,
    input  logic                            we,
    input  logic [cmil_pkg::ADDR_W-1:0]     waddr,
    input  cmil_pkg::color_entry_t          wdata,
    input  logic                            re,
    input  logic [cmil_pkg::ADDR_W-1:0]     raddr_a,
    input  logic [cmil_pkg::ADDR_W-1:0]     raddr_b,
    output cmil_pkg::color_entry_t          rdata_a,
    output cmil_pkg::color_entry_t          rdata_b
);

    cmil_pkg::color_entry_t mem [cmil_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // a read on the edge of a write returns the old entry
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: sv/cmil_blend.sv
// ----------------------------------------------------------------------------
// cmil_blend
// One color component: linear blend of two entries, saturate, scale to 8 bits.
// ----------------------------------------------------------------------------
module cmil_blend
(
    input  logic                             clk,
    input  logic                             adv_acc,
    input  logic                             adv_pix,
    input  logic [cmil_pkg::COMP_W-1:0]      lo,
    input  logic [cmil_pkg::COMP_W-1:0]      hi,
    input  logic [cmil_pkg::FRAC_W-1:0]      frac,
    output logic [cmil_pkg::PIXEL_W-1:0]     pixel
);

    logic [cmil_pkg::PROD_W-1:0]    acc_reg;
    logic [cmil_pkg::PROD_W-1:0]    acc_next;
    logic [cmil_pkg::PROD_W-1:0]    prod_lo;
    logic [cmil_pkg::PROD_W-1:0]    prod_hi;
    logic [cmil_pkg::FRAC_W-1:0]    inv_frac;
    logic [cmil_pkg::SAT_W-1:0]     sat;
    logic [cmil_pkg::SCALED_W-1:0]  scaled;
    logic [cmil_pkg::PIXEL_W-1:0]   pixel_reg;
    logic [cmil_pkg::PIXEL_W-1:0]   pixel_next;

    assign inv_frac = cmil_pkg::ONE - frac;
    assign prod_lo  = cmil_pkg::PROD_W'(inv_frac) * cmil_pkg::PROD_W'(lo);
    assign prod_hi  = cmil_pkg::PROD_W'(frac) * cmil_pkg::PROD_W'(hi);
    assign acc_next = prod_lo + prod_hi;

    // saturate to 1.0, multiply by 255 as shift-subtract, round half up
    assign sat = (acc_reg > cmil_pkg::PROD_W'(cmil_pkg::FULL_SCALE)) ?
                 cmil_pkg::FULL_SCALE : acc_reg[cmil_pkg::SAT_W-1:0];
    assign scaled = (cmil_pkg::SCALED_W'(sat) << cmil_pkg::PIXEL_W)
                    - cmil_pkg::SCALED_W'(sat) + cmil_pkg::ROUND_HALF;
    assign pixel_next = scaled[cmil_pkg::FRACTION_BITS + cmil_pkg::COLOR_BITS +: cmil_pkg::PIXEL_W];

    always_ff @(posedge clk)
    begin
        if (adv_acc)
        begin
            acc_reg <= acc_next;
        end
        if (adv_pix)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// File: sv/colormap_interpolating_lookup_top.sv
// ----------------------------------------------------------------------------
// colormap_interpolating_lookup_top
// Pseudo-color mapper: scalar in, linearly interpolated 8-bit RGB out.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries request words. operation OP_WRITE stores red_in, green_in
//   and blue_in at entry_index of the color table and gives no pixel word;
//   OP_LOOKUP maps value (signed, 1/65536 units, clamped to [0,1]) to one
//   pixel word on pix_out. The APB register entries_in_use sets how many
//   table entries span [0,1]; write it only while the block is idle.
//   Throughput is one request word per cycle while pix_out does not stall,
//   writes and lookups mixed in any order. A lookup's pixel word passes
//   through registered stages in order: index/fraction, table read, blend,
//   then scale-and-round into the output register. The dual-read table
//   port fetches both neighbors in one read.
//   A write takes effect at its accepting edge; a lookup ahead of it reads
//   the old entry, a lookup behind it the new one.
//   Reset empties the pipeline and sets entries_in_use to 256; the table
//   holds garbage until written, so read only written entries.
//   When pix_out stalls, each stage holds only if the one after it is full
//   and held, so bubbles fill before pix_in.ready drops.
// ----------------------------------------------------------------------------
module colormap_interpolating_lookup_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    cmil_in_if.sink                           pix_in,
    cmil_out_if.source                        pix_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cmil_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    cmil_pkg::cmil_cfg_t cfg;

    // stage valids: 1 index/fraction, 2 table data, 3 blend sum, 4 output
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic adv1, adv2, adv3, adv4;

    logic                            accept;
    logic                            table_we;
    logic [cmil_pkg::COMP_W-1:0]     clamped;
    logic [cmil_pkg::POS_W-1:0]      pos;
    logic [cmil_pkg::ADDR_W:0]       pos_index;
    logic [cmil_pkg::ADDR_W-1:0]     idx_next;
    logic [cmil_pkg::FRAC_W-1:0]     frac1_next;
    logic [cmil_pkg::ADDR_W-1:0]     idx_reg;
    logic [cmil_pkg::FRAC_W-1:0]     frac1_reg;
    logic [cmil_pkg::FRAC_W-1:0]     frac2_reg;
    cmil_pkg::color_entry_t          entry_lo;
    cmil_pkg::color_entry_t          entry_hi;
    cmil_pkg::color_entry_t          wr_entry;

    cmil_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance a stage when it is empty or the next one advances.
    assign adv4 = !v4_reg || pix_out.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pix_in.ready = adv1;
    assign accept       = pix_in.valid && adv1;
    assign table_we     = accept && (pix_in.operation == cmil_pkg::OP_WRITE);

    // Clamp the scalar to [0,1]: negative gives 0, above one gives one.
    always_comb
    begin
        if (pix_in.value[cmil_pkg::VALUE_W-1])
        begin
            clamped = '0;
        end
        else if (pix_in.value[cmil_pkg::VALUE_W-2:0] > (cmil_pkg::VALUE_W-1)'(cmil_pkg::ONE))
        begin
            clamped = cmil_pkg::ONE;
        end
        else
        begin
            clamped = pix_in.value[cmil_pkg::COMP_W-1:0];
        end
    end

    // Scale by entries minus one, split into index and fraction.
    assign pos       = cmil_pkg::POS_W'(clamped) * cmil_pkg::POS_W'(cfg.last_index);
    assign pos_index = pos[cmil_pkg::FRACTION_BITS +: (cmil_pkg::ADDR_W + 1)];

    always_comb
    begin
        if (pos_index >= {1'b0, cfg.last_index})
        begin
            // top end: step back to the last pair, take all of the upper entry
            idx_next   = cfg.last_index - cmil_pkg::ADDR_W'(1);
            frac1_next = cmil_pkg::ONE;
        end
        else
        begin
            idx_next   = pos_index[cmil_pkg::ADDR_W-1:0];
            frac1_next = {1'b0, pos[cmil_pkg::FRACTION_BITS-1:0]};
        end
    end

    always_comb
    begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        v4_next = v4_reg;
        if (adv1)
        begin
            v1_next = accept && (pix_in.operation == cmil_pkg::OP_LOOKUP);
        end
        if (adv2)
        begin
            v2_next = v1_reg;
        end
        if (adv3)
        begin
            v3_next = v2_reg;
        end
        if (adv4)
        begin
            v4_next = v3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Payload registers: hold on stall, no reset.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            idx_reg   <= idx_next;
            frac1_reg <= frac1_next;
        end
        if (adv2)
        begin
            frac2_reg <= frac1_reg;
        end
    end

    assign wr_entry.red   = pix_in.red_in;
    assign wr_entry.green = pix_in.green_in;
    assign wr_entry.blue  = pix_in.blue_in;

    // Both neighbors in one read; the read data register is stage 2.
    cmil_table_ram u_table
    (
        .clk     (clk),
        .we      (table_we),
        .waddr   (pix_in.entry_index),
        .wdata   (wr_entry),
        .re      (adv2),
        .raddr_a (idx_reg),
        .raddr_b (idx_reg + cmil_pkg::ADDR_W'(1)),
        .rdata_a (entry_lo),
        .rdata_b (entry_hi)
    );

    cmil_blend u_blend_red
    (
        .clk     (clk),
        .adv_acc (adv3),
        .adv_pix (adv4),
        .lo      (entry_lo.red),
        .hi      (entry_hi.red),
        .frac    (frac2_reg),
        .pixel   (pix_out.red)
    );

    cmil_blend u_blend_green
    (
        .clk     (clk),
        .adv_acc (adv3),
        .adv_pix (adv4),
        .lo      (entry_lo.green),
        .hi      (entry_hi.green),
        .frac    (frac2_reg),
        .pixel   (pix_out.green)
    );

    cmil_blend u_blend_blue
    (
        .clk     (clk),
        .adv_acc (adv3),
        .adv_pix (adv4),
        .lo      (entry_lo.blue),
        .hi      (entry_hi.blue),
        .frac    (frac2_reg),
        .pixel   (pix_out.blue)
    );

    assign pix_out.valid = v4_reg;

    // Assertions
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (idx_reg < cfg.last_index))
        else $error("lookup index past the last usable pair");

    a_frac_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (frac1_reg <= cmil_pkg::ONE))
        else $error("lookup fraction above one");

    a_held_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !pix_out.ready) |-> !pix_in.ready)
        else $error("request taken while the pipeline is full and held");

    a_blend_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && adv4) |=> pix_out.valid)
        else $error("blended word lost before the output register");

endmodule

// File: verif/colormap_interpolating_lookup_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colormap_interpolating_lookup_top_tb
// Self-checking bench for the interpolating colormap lookup.
// Streams table writes and scalar lookups into the block under random
// sender gaps and receiver stalls. Each accepted word updates a shadow color
// table or predicts the pixel word it must produce, and every pixel word that
// comes out is compared channel by channel. The entry count register is
// swept across its range, extremes and out-of-range values included.
// ----------------------------------------------------------------------------
module colormap_interpolating_lookup_top_tb;

    localparam int RESET_CYCLES  = 12;
    localparam int PIPE_LATENCY  = 4;
    localparam int SETTLE_CYCLES = 3 * PIPE_LATENCY;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_WORDS   = 60;
    localparam int HOLD_PHASE    = 7;
    localparam int LONG_HOLD     = 300;
    localparam int UNUSED_REG    = 1;

    localparam logic [cmil_pkg::APB_ADDR_W-1:0] ENTRIES_ADDR =
        cmil_pkg::APB_ADDR_W'(4 * cmil_pkg::REG_ENTRIES);
    localparam logic [cmil_pkg::APB_ADDR_W-1:0] UNUSED_ADDR  =
        cmil_pkg::APB_ADDR_W'(4 * UNUSED_REG);

    // 1.0 in the scalar and fraction units
    localparam bit [63:0] UNIT = 64'd1 << cmil_pkg::FRACTION_BITS;

    typedef struct {
        logic                                operation;
        logic [cmil_pkg::ADDR_W-1:0]         entry_index;
        logic [cmil_pkg::COMP_W-1:0]         red_in;
        logic [cmil_pkg::COMP_W-1:0]         green_in;
        logic [cmil_pkg::COMP_W-1:0]         blue_in;
        logic signed [cmil_pkg::VALUE_W-1:0] value;
    } request_word_t;

    typedef struct {
        logic [cmil_pkg::PIXEL_W-1:0] red;
        logic [cmil_pkg::PIXEL_W-1:0] green;
        logic [cmil_pkg::PIXEL_W-1:0] blue;
    } pixel_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [cmil_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    cmil_in_if  pix_in_bus();
    cmil_out_if pix_out_bus();

    colormap_interpolating_lookup_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Words waiting to be offered, and pixel words the block still owes us.
    request_word_t stim_q[$];
    pixel_word_t   expected_pixels[$];

    // Shadow of the color table and of the entry count register.
    cmil_pkg::color_entry_t         table_copy[cmil_pkg::TABLE_DEPTH];
    logic [cmil_pkg::ENTRIES_W-1:0] entries_cfg;

    // Entries the stimulus has already written; lookups never read others.
    bit planned[cmil_pkg::TABLE_DEPTH];

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    bit          long_hold_req;
    bit          long_hold_taken;
    int unsigned hold_left;

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned write_count;
    int unsigned lookup_count;
    int unsigned pixels_checked;
    int unsigned settings_used;

    // ------------------------------------------------------------------------
    // Pixel prediction
    // ------------------------------------------------------------------------

    // Entry count as the block uses it: clamp into [2, TABLE_DEPTH].
    function automatic int unsigned span_count(logic [cmil_pkg::ENTRIES_W-1:0] cfg);
        int unsigned n;
        n = 32'(cfg);
        if (n < 2)
            n = 2;
        if (n > cmil_pkg::TABLE_DEPTH)
            n = cmil_pkg::TABLE_DEPTH;
        return n;
    endfunction

    // Clamp the scalar to [0,1], scale by (entries - 1) and split it into the
    // lower neighbor and the blend fraction. The top end folds back onto the
    // last pair with a fraction of one.
    function automatic void locate(input logic signed [cmil_pkg::VALUE_W-1:0] value,
                                   input logic [cmil_pkg::ENTRIES_W-1:0] cfg,
                                   output int unsigned idx,
                                   output logic [cmil_pkg::FRAC_W-1:0] frac);
        bit [63:0]   scalar;
        bit [63:0]   pos;
        int unsigned n;
        n = span_count(cfg);
        if (value[cmil_pkg::VALUE_W-1])
            scalar = '0;
        else
            scalar = 64'(value[cmil_pkg::VALUE_W-2:0]);
        if (scalar > UNIT)
            scalar = UNIT;
        pos  = scalar * 64'(n - 1);
        idx  = 32'(pos >> cmil_pkg::FRACTION_BITS);
        frac = cmil_pkg::FRAC_W'(pos[cmil_pkg::FRACTION_BITS-1:0]);
        if (idx >= n - 1)
        begin
            idx  = n - 2;
            frac = cmil_pkg::FRAC_W'(UNIT);
        end
    endfunction

    // Exact linear blend, saturate at 1.0, scale by 255 and round half up.
    function automatic logic [cmil_pkg::PIXEL_W-1:0] blend(
        logic [cmil_pkg::COMP_W-1:0] lo,
        logic [cmil_pkg::COMP_W-1:0] hi,
        logic [cmil_pkg::FRAC_W-1:0] frac);
        bit [63:0] mix;
        bit [63:0] full;
        full = 64'd1 << (cmil_pkg::FRACTION_BITS + cmil_pkg::COLOR_BITS);
        mix  = (UNIT - 64'(frac)) * 64'(lo) + 64'(frac) * 64'(hi);
        if (mix > full)
            mix = full;
        mix = 64'd255 * mix + (full >> 1);
        return cmil_pkg::PIXEL_W'(mix >> (cmil_pkg::FRACTION_BITS + cmil_pkg::COLOR_BITS));
    endfunction

    function automatic pixel_word_t map_pixel(logic signed [cmil_pkg::VALUE_W-1:0] value);
        int unsigned                 idx;
        logic [cmil_pkg::FRAC_W-1:0] frac;
        pixel_word_t                 px;
        locate(value, entries_cfg, idx, frac);
        px.red   = blend(table_copy[idx].red,   table_copy[idx + 1].red,   frac);
        px.green = blend(table_copy[idx].green, table_copy[idx + 1].green, frac);
        px.blue  = blend(table_copy[idx].blue,  table_copy[idx + 1].blue,  frac);
        return px;
    endfunction

    // Apply one accepted request word to the shadow state.
    function automatic void apply_request(request_word_t req);
        if (req.operation == cmil_pkg::OP_WRITE)
        begin
            table_copy[req.entry_index] = '{red: req.red_in, green: req.green_in,
                                            blue: req.blue_in};
            write_count++;
        end
        else
        begin
            expected_pixels.push_back(map_pixel(req.value));
            lookup_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    // Mostly legal fractions, with exact 0 and 1.0 and some above 1.0 so the
    // saturation path gets exercised.
    function automatic logic [cmil_pkg::COMP_W-1:0] pick_fraction();
        case ($urandom_range(9))
            0:       return '0;
            1:       return cmil_pkg::COMP_W'(UNIT);
            2, 3:    return cmil_pkg::COMP_W'($urandom);
            default: return cmil_pkg::COMP_W'($urandom_range(int'(UNIT)));
        endcase
    endfunction

    // Mostly in-range scalars; a share spans the whole 18-bit field so
    // negatives and values above 1.0 show up.
    function automatic logic signed [cmil_pkg::VALUE_W-1:0] pick_scalar();
        case ($urandom_range(9))
            0:       return cmil_pkg::VALUE_W'(UNIT);
            1:       return '0;
            2, 3, 4: return cmil_pkg::VALUE_W'($urandom);
            default: return cmil_pkg::VALUE_W'($urandom_range(int'(UNIT)));
        endcase
    endfunction

    function automatic void queue_write(int unsigned idx, logic [cmil_pkg::COMP_W-1:0] r,
                                        logic [cmil_pkg::COMP_W-1:0] g,
                                        logic [cmil_pkg::COMP_W-1:0] b);
        request_word_t req;
        req.operation   = cmil_pkg::OP_WRITE;
        req.entry_index = cmil_pkg::ADDR_W'(idx);
        req.red_in      = r;
        req.green_in    = g;
        req.blue_in     = b;
        req.value       = cmil_pkg::VALUE_W'($urandom);   // ignored by a write
        stim_q.push_back(req);
        planned[idx] = 1'b1;
    endfunction

    function automatic void queue_lookup(logic signed [cmil_pkg::VALUE_W-1:0] value);
        request_word_t               req;
        int unsigned                 idx;
        logic [cmil_pkg::FRAC_W-1:0] frac;
        locate(value, entries_cfg, idx, frac);
        // both neighbors are read, so fill any that were never written first
        for (int k = 0; k < 2; k++)
            if (!planned[idx + k])
                queue_write(idx + k, pick_fraction(), pick_fraction(), pick_fraction());
        req.operation   = cmil_pkg::OP_LOOKUP;
        req.entry_index = cmil_pkg::ADDR_W'($urandom);   // the rest is ignored by a lookup
        req.red_in      = cmil_pkg::COMP_W'($urandom);
        req.green_in    = cmil_pkg::COMP_W'($urandom);
        req.blue_in     = cmil_pkg::COMP_W'($urandom);
        req.value       = value;
        stim_q.push_back(req);
    endfunction

    // ------------------------------------------------------------------------
    // Checking helpers
    // ------------------------------------------------------------------------

    task automatic check_channel(string channel, logic [cmil_pkg::PIXEL_W-1:0] want,
                                 logic [cmil_pkg::PIXEL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, channel, want, got);
            error_count++;
        end
    endtask

    // Register write: setup cycle, then access until pready.
    task automatic write_reg(logic [cmil_pkg::APB_ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // only writes to the entry count address update the shadow count
        if (addr == ENTRIES_ADDR)
            entries_cfg = data[cmil_pkg::ENTRIES_W-1:0];
    endtask

    // Wait until every queued word is in and every pixel word is out, then
    // give the pipeline time to finish a trailing write.
    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (stim_q.size() != 0 || pix_in_bus.valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued request words, hold each until it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        request_word_t req;
        if (rst_n)
        begin
            if (pix_in_bus.valid && pix_in_bus.ready)
            begin
                req.operation   = pix_in_bus.operation;
                req.entry_index = pix_in_bus.entry_index;
                req.red_in      = pix_in_bus.red_in;
                req.green_in    = pix_in_bus.green_in;
                req.blue_in     = pix_in_bus.blue_in;
                req.value       = pix_in_bus.value;
                apply_request(req);
            end
            // advance only when nothing is on offer or the offer was taken
            if (!pix_in_bus.valid || pix_in_bus.ready)
            begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    req = stim_q.pop_front();
                    pix_in_bus.valid       <= 1'b1;
                    pix_in_bus.operation   <= req.operation;
                    pix_in_bus.entry_index <= req.entry_index;
                    pix_in_bus.red_in      <= req.red_in;
                    pix_in_bus.green_in    <= req.green_in;
                    pix_in_bus.blue_in     <= req.blue_in;
                    pix_in_bus.value       <= req.value;
                end
                else
                    pix_in_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off: count the cycles the receiver stays away, on request.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req && !long_hold_taken)
            begin
                hold_left       <= LONG_HOLD;
                long_hold_taken <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each pixel word with the oldest prediction and drive
    // the receiver's ready, held low while a long hold-off runs.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_word_t want;
        if (rst_n)
        begin
            if (pix_out_bus.valid && pix_out_bus.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel word, expected none, actual %0d/%0d/%0d",
                             $time, pix_out_bus.red, pix_out_bus.green, pix_out_bus.blue);
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_channel("red",   want.red,   pix_out_bus.red);
                    check_channel("green", want.green, pix_out_bus.green);
                    check_channel("blue",  want.blue,  pix_out_bus.blue);
                    pixels_checked++;
                end
            end
            if (hold_left != 0)
                pix_out_bus.ready <= 1'b0;
            else
                pix_out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drop the run if it stalls far beyond the slowest legal schedule.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words queued, %0d pixel words owed",
                     cycle_count, stim_q.size(), expected_pixels.size());
            $display("colormap_interpolating_lookup_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned entry_settings[PHASE_COUNT];
        entry_settings = '{0, 1, 511, 300, 3, 17, 255, 257, 2, 128};

        // quiet, known values on every input before reset lifts
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        pix_in_bus.valid       = 1'b0;
        pix_in_bus.operation   = cmil_pkg::OP_WRITE;
        pix_in_bus.entry_index = '0;
        pix_in_bus.red_in      = '0;
        pix_in_bus.green_in    = '0;
        pix_in_bus.blue_in     = '0;
        pix_in_bus.value       = '0;
        pix_out_bus.ready      = 1'b0;
        entries_cfg            = cmil_pkg::ENTRIES_RESET;
        send_gap_pct           = 16;
        recv_stall_pct         = 54;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, full 256-entry span from reset: extreme colors at both
        // ends of the table, above-1.0 fractions, and scalars at and past
        // both clamp points.
        queue_write(0, '0, cmil_pkg::COMP_W'(UNIT), '1);
        queue_write(1, cmil_pkg::COMP_W'(UNIT), '0, cmil_pkg::COMP_W'(1));
        queue_write(cmil_pkg::TABLE_DEPTH - 1, '1, cmil_pkg::COMP_W'(UNIT - 1),
                    cmil_pkg::COMP_W'(UNIT));
        queue_write(cmil_pkg::TABLE_DEPTH - 2, cmil_pkg::COMP_W'(12345), '1, '0);
        queue_lookup({1'b1, {(cmil_pkg::VALUE_W-1){1'b0}}});  // most negative
        queue_lookup('1);                                     // just below zero
        queue_lookup('0);
        queue_lookup(cmil_pkg::VALUE_W'(1));
        queue_lookup(cmil_pkg::VALUE_W'(256));                // still on the first pair
        queue_lookup(cmil_pkg::VALUE_W'(UNIT - 1));           // last pair, fraction below one
        queue_lookup(cmil_pkg::VALUE_W'(UNIT));               // top end folds back
        queue_lookup(cmil_pkg::VALUE_W'(UNIT + 1));           // just above 1.0
        queue_lookup({1'b0, {(cmil_pkg::VALUE_W-1){1'b1}}});  // most positive
        queue_lookup(cmil_pkg::VALUE_W'(UNIT / 2));           // middle of the table
        wait_until_idle();
        settings_used++;

        // an unmapped register address must leave the entry count alone
        write_reg(UNUSED_ADDR, 32'h1FF);
        // narrowest span: entries 0 and 1 only
        write_reg(ENTRIES_ADDR, 32'd2);
        settings_used++;
        queue_lookup('0);
        queue_lookup(cmil_pkg::VALUE_W'(UNIT / 4));
        queue_lookup(cmil_pkg::VALUE_W'(UNIT / 2));
        queue_lookup(cmil_pkg::VALUE_W'(UNIT));
        queue_lookup({1'b1, {(cmil_pkg::VALUE_W-1){1'b0}}});
        queue_lookup({1'b0, {(cmil_pkg::VALUE_W-1){1'b1}}});
        wait_until_idle();

        // Random phases, one entry count each. Counts below 2 and above the
        // table depth are included; the last count is drawn at random.
        entry_settings[PHASE_COUNT - 1] = $urandom_range(cmil_pkg::TABLE_DEPTH, 2);
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_reg(ENTRIES_ADDR, entry_settings[p]);
            settings_used++;
            // sender rarely idles first, then the receiver; the tail runs flat out
            if (p < 4)
            begin
                send_gap_pct   = 16;
                recv_stall_pct = 54;
            end
            else if (p < HOLD_PHASE)
            begin
                send_gap_pct   = 54;
                recv_stall_pct = 16;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            repeat (PHASE_WORDS)
            begin
                if ($urandom_range(99) < 30)
                    queue_write($urandom_range(cmil_pkg::TABLE_DEPTH - 1), pick_fraction(),
                                pick_fraction(), pick_fraction());
                else
                    queue_lookup(pick_scalar());
            end
            // back up the pipeline once while the sender keeps offering
            if (p == HOLD_PHASE)
                long_hold_req = 1'b1;
            wait_until_idle();
        end

        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d pixel words never arrived", $time, expected_pixels.size());
            error_count++;
        end

        $display("Covered %0d table writes and %0d lookups over %0d entry-count settings;",
                 write_count, lookup_count, settings_used);
        $display("%0d pixel words compared, %0d errors, %0d cycles",
                 pixels_checked, error_count, cycle_count);
        if (error_count == 0)
            $display("colormap_interpolating_lookup_top test passed");
        else
            $display("colormap_interpolating_lookup_top test failed");
        $finish;
    end

endmodule
